// ----- src/ybs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_pkg
// Shared types, character codes and CRC helper of the YMODEM block sender.
// ----------------------------------------------------------------------------
package ybs_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
  localparam int FRAME_BYTES = BLOCK_BYTES + 5;
  localparam int FIDX_W      = $clog2(FRAME_BYTES);

  // Frame layout: SOH, number, complement, data, CRC high, CRC low.
  localparam logic [FIDX_W-1:0] IDX_SOH    = FIDX_W'(0);
  localparam logic [FIDX_W-1:0] IDX_NUM    = FIDX_W'(1);
  localparam logic [FIDX_W-1:0] IDX_NUMC   = FIDX_W'(2);
  localparam logic [FIDX_W-1:0] IDX_DATA0  = FIDX_W'(3);
  localparam logic [FIDX_W-1:0] IDX_CRC_HI = FIDX_W'(3 + BLOCK_BYTES);
  localparam logic [FIDX_W-1:0] IDX_LAST   = FIDX_W'(FRAME_BYTES - 1);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BLOCK_BYTES);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES - 1);

  localparam logic [7:0]  CH_SOH   = 8'h01;
  localparam logic [7:0]  CH_EOT   = 8'h04;
  localparam logic [7:0]  CH_ACK   = 8'h06;
  localparam logic [7:0]  CH_NAK   = 8'h15;
  localparam logic [7:0]  CH_C     = 8'h43;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_FLUSH   = 3'd1,
    OP_END     = 3'd2,
    OP_START   = 3'd3,
    OP_AWAIT_C = 3'd4,
    OP_RX_CHAR = 3'd5,
    OP_PULL    = 3'd6
  } ybs_op_e;

  typedef enum logic [2:0] {
    ST_ACKED    = 3'd0,
    ST_C_RCVD   = 3'd1,
    ST_END_DONE = 3'd2,
    ST_BAD_REPLY = 3'd3,
    ST_NOT_C    = 3'd4,
    ST_REJECTED = 3'd5
  } ybs_status_e;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_WAIT_C      = 4'd1,
    PH_FRAME_TX    = 4'd2,
    PH_FRAME_REPLY = 4'd3,
    PH_EOT_TX      = 4'd4,
    PH_EOT_REPLY   = 4'd5,
    PH_END_WAIT_C  = 4'd6,
    PH_NULL_TX     = 4'd7,
    PH_NULL_REPLY  = 4'd8
  } ybs_phase_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_FILL
  } ybs_seq_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
  } ybs_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [2:0] status;
  } ybs_out_t;

  // Sequencer to protocol engine.
  typedef struct packed {
    logic exec;
    logic fill;
  } ybs_pctl_t;

  // Protocol engine to sequencer and block RAM.
  typedef struct packed {
    logic              res_valid;
    logic              fill_start;
    logic              fill_last;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
  } ybs_pstat_t;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/ybs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ybs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ybs_proto.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_proto
// Protocol engine: phase, counters and CRC, next-state and result decode.
// ----------------------------------------------------------------------------
module ybs_proto
  import ybs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ybs_pctl_t  ctl_i,
  input  ybs_in_t    cmd_i,
  input  logic [7:0] rdata_i,
  output ybs_pstat_t stat_o,
  output ybs_out_t   res_o
);

  ybs_phase_e        phase_q, phase_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        pkt_q, pkt_d;
  logic [FIDX_W-1:0] fidx_q, fidx_d;
  logic [7:0]        pad_q, pad_d;
  logic [FIDX_W-1:0] raddr_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fill_q  <= '0;
      crc_q   <= '0;
      pkt_q   <= '0;
      fidx_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      crc_q   <= crc_d;
      pkt_q   <= pkt_d;
      fidx_q  <= fidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q <= pad_d;
  end

  // Data byte address of the current frame position.
  assign raddr_full = fidx_q - IDX_DATA0;

  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    crc_d   = crc_q;
    pkt_d   = pkt_q;
    fidx_d  = fidx_q;
    pad_d   = pad_q;

    stat_o            = '0;
    stat_o.fill_last  = (fill_q == FILL_LAST);
    stat_o.ram_waddr  = fill_q[ADDR_W-1:0];
    stat_o.ram_wdata  = cmd_i.data_byte;
    stat_o.ram_raddr  = raddr_full[ADDR_W-1:0];
    res_o             = '0;

    if (ctl_i.fill) begin
      // padding sweep: one byte per cycle
      stat_o.ram_we    = 1'b1;
      stat_o.ram_wdata = pad_q;
      fill_d           = fill_q + FILL_W'(1);
      crc_d            = crc16_step(crc_q, pad_q);
    end else if (ctl_i.exec) begin
      case (ybs_op_e'(cmd_i.op))
        OP_ADD: begin
          if (phase_q != PH_IDLE) begin
            stat_o.res_valid = 1'b1;
            res_o.kind       = KIND_STATUS;
            res_o.status     = ST_REJECTED;
          end else if (fill_q < FILL_FULL) begin
            stat_o.ram_we = 1'b1;
            fill_d        = fill_q + FILL_W'(1);
            crc_d         = crc16_step(crc_q, cmd_i.data_byte);
            if (fill_q == FILL_LAST) begin
              phase_d = PH_FRAME_TX;
              fidx_d  = '0;
            end
          end
        end
        OP_FLUSH: begin
          if (phase_q != PH_IDLE) begin
            stat_o.res_valid = 1'b1;
            res_o.kind       = KIND_STATUS;
            res_o.status     = ST_REJECTED;
          end else if (fill_q != '0) begin
            pad_d             = cmd_i.data_byte;
            phase_d           = PH_FRAME_TX;
            fidx_d            = '0;
            stat_o.fill_start = (fill_q < FILL_FULL);
          end
        end
        OP_END: begin
          if (phase_q != PH_IDLE) begin
            stat_o.res_valid = 1'b1;
            res_o.kind       = KIND_STATUS;
            res_o.status     = ST_REJECTED;
          end else begin
            phase_d = PH_EOT_TX;
          end
        end
        OP_START: begin
          fill_d  = '0;
          crc_d   = '0;
          pkt_d   = '0;
          fidx_d  = '0;
          phase_d = PH_WAIT_C;
        end
        OP_AWAIT_C: begin
          if (phase_q != PH_IDLE) begin
            stat_o.res_valid = 1'b1;
            res_o.kind       = KIND_STATUS;
            res_o.status     = ST_REJECTED;
          end else begin
            phase_d = PH_WAIT_C;
          end
        end
        OP_RX_CHAR: begin
          case (phase_q)
            PH_WAIT_C: begin
              phase_d          = PH_IDLE;
              stat_o.res_valid = 1'b1;
              res_o.kind       = KIND_STATUS;
              if (cmd_i.data_byte == CH_C) begin
                fill_d       = '0;
                crc_d        = '0;
                res_o.status = ST_C_RCVD;
              end else begin
                res_o.status = ST_NOT_C;
              end
            end
            PH_FRAME_REPLY, PH_NULL_REPLY: begin
              if (cmd_i.data_byte == CH_ACK) begin
                fill_d           = '0;
                crc_d            = '0;
                pkt_d            = pkt_q + 8'd1;
                phase_d          = PH_IDLE;
                stat_o.res_valid = 1'b1;
                res_o.kind       = KIND_STATUS;
                res_o.status     = (phase_q == PH_NULL_REPLY) ? ST_END_DONE : ST_ACKED;
              end else if (cmd_i.data_byte == CH_NAK) begin
                fidx_d  = '0;
                phase_d = (phase_q == PH_NULL_REPLY) ? PH_NULL_TX : PH_FRAME_TX;
              end else begin
                fill_d           = '0;
                crc_d            = '0;
                phase_d          = PH_IDLE;
                stat_o.res_valid = 1'b1;
                res_o.kind       = KIND_STATUS;
                res_o.status     = ST_BAD_REPLY;
              end
            end
            PH_EOT_REPLY: begin
              if (cmd_i.data_byte == CH_ACK) begin
                phase_d = PH_END_WAIT_C;
              end else if (cmd_i.data_byte == CH_NAK) begin
                phase_d = PH_EOT_TX;
              end else begin
                fill_d           = '0;
                crc_d            = '0;
                phase_d          = PH_IDLE;
                stat_o.res_valid = 1'b1;
                res_o.kind       = KIND_STATUS;
                res_o.status     = ST_BAD_REPLY;
              end
            end
            PH_END_WAIT_C: begin
              if (cmd_i.data_byte != CH_C) begin
                phase_d          = PH_IDLE;
                stat_o.res_valid = 1'b1;
                res_o.kind       = KIND_STATUS;
                res_o.status     = ST_NOT_C;
              end else begin
                // null packet: zero block, numbered 0
                pkt_d             = '0;
                fill_d            = '0;
                crc_d             = '0;
                fidx_d            = '0;
                pad_d             = 8'h00;
                phase_d           = PH_NULL_TX;
                stat_o.fill_start = 1'b1;
              end
            end
            default: begin
              stat_o.res_valid = 1'b1;
              res_o.kind       = KIND_STATUS;
              res_o.status     = ST_REJECTED;
            end
          endcase
        end
        OP_PULL: begin
          stat_o.res_valid = 1'b1;
          if (phase_q == PH_FRAME_TX || phase_q == PH_NULL_TX) begin
            res_o.kind = KIND_TX;
            if (fidx_q == IDX_SOH) begin
              res_o.tx_byte = CH_SOH;
            end else if (fidx_q == IDX_NUM) begin
              res_o.tx_byte = pkt_q;
            end else if (fidx_q == IDX_NUMC) begin
              res_o.tx_byte = ~pkt_q;
            end else if (fidx_q < IDX_CRC_HI) begin
              res_o.tx_byte = rdata_i;
            end else if (fidx_q == IDX_CRC_HI) begin
              res_o.tx_byte = crc_q[15:8];
            end else begin
              res_o.tx_byte = crc_q[7:0];
            end
            if (fidx_q == IDX_LAST) begin
              fidx_d  = '0;
              phase_d = (phase_q == PH_NULL_TX) ? PH_NULL_REPLY : PH_FRAME_REPLY;
            end else begin
              fidx_d = fidx_q + FIDX_W'(1);
            end
          end else if (phase_q == PH_EOT_TX) begin
            res_o.kind    = KIND_TX;
            res_o.tx_byte = CH_EOT;
            phase_d       = PH_EOT_REPLY;
          end else begin
            res_o.kind   = KIND_STATUS;
            res_o.status = ST_REJECTED;
          end
        end
        default: begin
          stat_o.res_valid = 1'b1;
          res_o.kind       = KIND_STATUS;
          res_o.status     = ST_REJECTED;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fill |-> (fill_q < FILL_FULL))
    else $error("padding sweep past end of block");
`endif

endmodule

// ----- src/ymodem_block_sender_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ymodem_block_sender_unit
// YMODEM sender: 128-byte block buffer in RAM, CRC-16, frame and reply flow.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Word
//  command   in         start & !busy               cmd_i    (op, data_byte)
//  result    out        result_valid_o, 1 cycle     result_o (kind, tx_byte, status)
//
// For each command, the accept edge issues the block RAM read for the frame
// position and the next edge decodes and updates state. A result shows
// for one cycle after that, while the next command may already be accepted.
// Flush and the null packet then hold busy while padded bytes (up to 128) are written.
// Reset clears phase, counters and CRC; the block RAM keeps its contents.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module ymodem_block_sender_unit
  import ybs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  ybs_in_t  cmd_i,
  output logic     busy,
  output logic     result_valid_o,
  output ybs_out_t result_o
);

  ybs_seq_e   seq_q, seq_d;
  ybs_in_t    cmd_q;
  ybs_pctl_t  pctl;
  ybs_pstat_t pstat;
  ybs_out_t   res_d, res_q;
  logic       res_valid_q;
  logic       accept;
  logic [7:0] ram_rdata;

  assign busy   = (seq_q != SEQ_IDLE);
  assign accept = start && !busy;

  // Sequencer: accept, decode, then optionally sweep padding bytes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      res_valid_q <= pstat.res_valid;
    end
  end

  // Hold the command word and the result word; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    res_q <= res_d;
  end

  always_comb begin
    seq_d     = seq_q;
    pctl.exec = 1'b0;
    pctl.fill = 1'b0;
    case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          seq_d = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        pctl.exec = 1'b1;
        seq_d     = pstat.fill_start ? SEQ_FILL : SEQ_IDLE;
      end
      SEQ_FILL: begin
        pctl.fill = 1'b1;
        if (pstat.fill_last) begin
          seq_d = SEQ_IDLE;
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  ybs_proto u_proto (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (pctl),
    .cmd_i   (cmd_q),
    .rdata_i (ram_rdata),
    .stat_o  (pstat),
    .res_o   (res_d)
  );

  // Block buffer: written by add and padding, read when a command is accepted, ahead of a pull's decode.
  ybs_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_BYTES)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (pstat.ram_we),
    .waddr_i (pstat.ram_waddr),
    .wdata_i (pstat.ram_wdata),
    .re_i    (accept),
    .raddr_i (pstat.ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(seq_q == SEQ_EXEC))
    else $error("result strobe without a decode cycle");

  a_no_result_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_FILL) |-> !pstat.res_valid)
    else $error("result raised during padding sweep");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  a_write_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pstat.ram_we |-> busy)
    else $error("block RAM written while idle");
`endif

endmodule

// ----- verif/ybs_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_frame_checker
// Watches the command and result words of the YMODEM block sender, predicts
// each result from a private copy of the protocol state, and compares.
// ----------------------------------------------------------------------------
module ybs_frame_checker
  import ybs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  ybs_in_t  cmd_i,
  input  logic     busy_i,
  input  logic     result_valid_i,
  input  ybs_out_t result_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int MAX_REPORTS = 10;

  logic [7:0]  blk_mem [BLOCK_BYTES];
  int          blk_fill  = 0;
  logic [15:0] blk_crc   = '0;
  logic [7:0]  pkt_num   = '0;
  ybs_phase_e  phase_q   = PH_IDLE;
  int          frame_pos = 0;
  int          fail_cnt  = 0;
  ybs_out_t    awaited_results [$];

  // CRC-16/XMODEM, one bit at a time with the feedback taken from the top bit.
  function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic void append_byte(logic [7:0] b);
    if (blk_fill < BLOCK_BYTES) begin
      blk_mem[blk_fill] = b;
      blk_fill++;
      blk_crc = crc_add(blk_crc, b);
    end
  endfunction

  function automatic void clear_block();
    blk_fill = 0;
    blk_crc  = '0;
  endfunction

  function automatic logic [7:0] frame_byte_at(int pos);
    if (pos == 0) return CH_SOH;
    if (pos == 1) return pkt_num;
    if (pos == 2) return ~pkt_num;
    if (pos < 3 + BLOCK_BYTES) return blk_mem[pos - 3];
    if (pos == 3 + BLOCK_BYTES) return blk_crc[15:8];
    return blk_crc[7:0];
  endfunction

  function automatic ybs_out_t status_word(ybs_status_e s);
    ybs_out_t w;
    w.kind    = KIND_STATUS;
    w.tx_byte = 8'h00;
    w.status  = s;
    return w;
  endfunction

  function automatic ybs_out_t tx_word(logic [7:0] b);
    ybs_out_t w;
    w.kind    = KIND_TX;
    w.tx_byte = b;
    w.status  = 3'b000;
    return w;
  endfunction

  // Advance the private state by one command word; report the result it causes.
  function automatic void predict_reply(input ybs_in_t w, output bit has_res,
                                        output ybs_out_t res);
    has_res = 1'b0;
    res     = '0;
    case (ybs_op_e'(w.op))
      OP_ADD: begin
        if (phase_q != PH_IDLE) begin
          has_res = 1'b1;
          res     = status_word(ST_REJECTED);
        end else begin
          append_byte(w.data_byte);
          if (blk_fill >= BLOCK_BYTES) begin
            phase_q   = PH_FRAME_TX;
            frame_pos = 0;
          end
        end
      end
      OP_FLUSH: begin
        if (phase_q != PH_IDLE) begin
          has_res = 1'b1;
          res     = status_word(ST_REJECTED);
        end else if (blk_fill != 0) begin
          while (blk_fill < BLOCK_BYTES) append_byte(w.data_byte);
          phase_q   = PH_FRAME_TX;
          frame_pos = 0;
        end
      end
      OP_END: begin
        if (phase_q != PH_IDLE) begin
          has_res = 1'b1;
          res     = status_word(ST_REJECTED);
        end else begin
          phase_q = PH_EOT_TX;
        end
      end
      OP_START: begin
        clear_block();
        pkt_num   = '0;
        frame_pos = 0;
        phase_q   = PH_WAIT_C;
      end
      OP_AWAIT_C: begin
        if (phase_q != PH_IDLE) begin
          has_res = 1'b1;
          res     = status_word(ST_REJECTED);
        end else begin
          phase_q = PH_WAIT_C;
        end
      end
      OP_RX_CHAR: begin
        case (phase_q)
          PH_WAIT_C: begin
            phase_q = PH_IDLE;
            has_res = 1'b1;
            if (w.data_byte == CH_C) begin
              clear_block();
              res = status_word(ST_C_RCVD);
            end else begin
              res = status_word(ST_NOT_C);
            end
          end
          PH_FRAME_REPLY, PH_NULL_REPLY: begin
            if (w.data_byte == CH_ACK) begin
              has_res = 1'b1;
              res     = status_word((phase_q == PH_NULL_REPLY) ? ST_END_DONE : ST_ACKED);
              clear_block();
              pkt_num = pkt_num + 8'd1;
              phase_q = PH_IDLE;
            end else if (w.data_byte == CH_NAK) begin
              frame_pos = 0;
              phase_q   = (phase_q == PH_NULL_REPLY) ? PH_NULL_TX : PH_FRAME_TX;
            end else begin
              has_res = 1'b1;
              res     = status_word(ST_BAD_REPLY);
              clear_block();
              phase_q = PH_IDLE;
            end
          end
          PH_EOT_REPLY: begin
            if (w.data_byte == CH_ACK) begin
              phase_q = PH_END_WAIT_C;
            end else if (w.data_byte == CH_NAK) begin
              phase_q = PH_EOT_TX;
            end else begin
              has_res = 1'b1;
              res     = status_word(ST_BAD_REPLY);
              clear_block();
              phase_q = PH_IDLE;
            end
          end
          PH_END_WAIT_C: begin
            if (w.data_byte != CH_C) begin
              has_res = 1'b1;
              res     = status_word(ST_NOT_C);
              phase_q = PH_IDLE;
            end else begin
              // null packet: number 0, all-zero payload
              pkt_num = '0;
              clear_block();
              while (blk_fill < BLOCK_BYTES) append_byte(8'h00);
              frame_pos = 0;
              phase_q   = PH_NULL_TX;
            end
          end
          default: begin
            has_res = 1'b1;
            res     = status_word(ST_REJECTED);
          end
        endcase
      end
      OP_PULL: begin
        if (phase_q == PH_FRAME_TX || phase_q == PH_NULL_TX) begin
          has_res = 1'b1;
          res     = tx_word(frame_byte_at(frame_pos));
          frame_pos++;
          if (frame_pos >= FRAME_BYTES) begin
            frame_pos = 0;
            phase_q   = (phase_q == PH_NULL_TX) ? PH_NULL_REPLY : PH_FRAME_REPLY;
          end
        end else if (phase_q == PH_EOT_TX) begin
          has_res = 1'b1;
          res     = tx_word(CH_EOT);
          phase_q = PH_EOT_REPLY;
        end else begin
          has_res = 1'b1;
          res     = status_word(ST_REJECTED);
        end
      end
      default: begin
        has_res = 1'b1;
        res     = status_word(ST_REJECTED);
      end
    endcase
  endfunction

  function automatic void note_failure(string what, ybs_out_t exp_w, ybs_out_t got_w);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      $display("[%0t] %s: expected kind=%0d tx=%02h status=%0d, got kind=%0d tx=%02h status=%0d",
               $realtime, what, exp_w.kind, exp_w.tx_byte, exp_w.status,
               got_w.kind, got_w.tx_byte, got_w.status);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit       has_res;
    ybs_out_t next_res;
    ybs_out_t oldest;
    if (!rst_ni) begin
      awaited_results.delete();
      foreach (blk_mem[i]) blk_mem[i] = 8'h00;
      clear_block();
      pkt_num   = '0;
      frame_pos = 0;
      phase_q   = PH_IDLE;
    end else begin
      // Results come from earlier words, so match them before taking a new word.
      if (result_valid_i) begin
        if (awaited_results.size() == 0) begin
          note_failure("unexpected result word", '0, result_i);
        end else begin
          oldest = awaited_results.pop_front();
          if (result_i.kind !== oldest.kind || result_i.tx_byte !== oldest.tx_byte ||
              result_i.status !== oldest.status) begin
            note_failure("result word mismatch", oldest, result_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_reply(cmd_i, has_res, next_res);
        if (has_res) awaited_results.push_back(next_res);
      end
    end
    fail_count_o = fail_cnt;
    pending_o    = awaited_results.size();
  end

endmodule

// ----- verif/tb_ymodem_block_sender_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ymodem_block_sender_unit
// Drives command words into the YMODEM block sender: a short directed pass
// over rejections and the EOT flow, then randomized transfer sessions with
// frames, NAK resends, bad replies, aborts and null packets, mixed with noise.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_ymodem_block_sender_unit;
  import ybs_pkg::*;

  localparam int ITEM_TARGET  = 1400;
  // Slowest run: ~1500 words, each with a possible random gap and padding
  // pass; allow several times that.
  localparam int CYCLE_LIMIT  = 1000000;
  // Pipeline depth plus one full padding pass.
  localparam int DRAIN_CYCLES = 300;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  ybs_in_t  cmd_i  = '0;
  logic     busy;
  logic     result_valid_o;
  ybs_out_t result_o;

  int fail_count;
  int pending;
  int cycle_cnt   = 0;
  int burst_left  = 0;
  int items_sent  = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ymodem_block_sender_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  ybs_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (cmd_i),
    .busy_i         (busy),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Issue one command word. Inputs change on the falling edge only; the word
  // is taken at the rising edge where start is high and busy is low. Bursts of
  // random length alternate with random gaps, and some bursts are long enough
  // to give stretches with no idling at all.
  task automatic send_word(input ybs_op_e op, input logic [7:0] d);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      start = 1'b0;
      gap   = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
    end
    start          = 1'b1;
    cmd_i.op        = op;
    cmd_i.data_byte = d;
    // hold the word until the block takes it
    do @(posedge clk_i); while (busy);
    burst_left--;
    items_sent++;
  endtask

  // Drop start and hold off until every predicted result word has come back.
  task automatic wait_results_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Any character but 'C'.
  function automatic logic [7:0] byte_except_c();
    logic [7:0] b;
    b = rand_byte();
    if (b == CH_C) b = ~CH_C;
    return b;
  endfunction

  // Any character but ACK and NAK: a bad reply.
  function automatic logic [7:0] bad_reply_byte();
    logic [7:0] b;
    b = rand_byte();
    while (b == CH_ACK || b == CH_NAK) b = rand_byte();
    return b;
  endfunction

  // Pull a whole frame. Now and then slip in a word that the transmit phase
  // must reject (add, flush, end, await C, stray character). Returns 0 if the
  // frame was cut short by a start, after which the wait for 'C' is answered.
  task automatic pull_frame(output bit done);
    done = 1'b1;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if ($urandom_range(0, 399) == 0) begin
        send_word(OP_START, rand_byte());
        send_word(OP_RX_CHAR, CH_C);
        done = 1'b0;
        return;
      end
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 4))
          0: send_word(OP_ADD, rand_byte());
          1: send_word(OP_FLUSH, rand_byte());
          2: send_word(OP_END, rand_byte());
          3: send_word(OP_AWAIT_C, rand_byte());
          default: send_word(OP_RX_CHAR, rand_byte());
        endcase
      end
      send_word(OP_PULL, rand_byte());
    end
  endtask

  // One data block from idle: fill, pad if partial, send, and answer.
  task automatic run_block();
    int  n;
    int  pick;
    bit  done;
    pick = $urandom_range(0, 3);
    // most blocks are partial and padded; some fill all 128 bytes by hand
    if (pick <= 1) n = $urandom_range(1, 16);
    else if (pick == 2) n = $urandom_range(17, BLOCK_BYTES - 1);
    else n = BLOCK_BYTES;
    for (int i = 0; i < n; i++) send_word(OP_ADD, rand_byte());
    if (n < BLOCK_BYTES) send_word(OP_FLUSH, rand_byte());
    forever begin
      pull_frame(done);
      if (!done) return;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_word(OP_RX_CHAR, CH_ACK);
        return;
      end else if (pick < 85) begin
        send_word(OP_RX_CHAR, CH_NAK);   // resend the same frame
      end else begin
        send_word(OP_RX_CHAR, bad_reply_byte());
        return;
      end
    end
  endtask

  // Close a transfer: EOT until ACK, wait for 'C', then the null packet.
  task automatic run_end();
    int pick;
    bit done;
    // a partial block left behind must be replaced by the null packet
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) send_word(OP_ADD, rand_byte());
    end
    send_word(OP_END, rand_byte());
    forever begin
      send_word(OP_PULL, rand_byte());
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_word(OP_RX_CHAR, CH_NAK);
      end else if (pick < 23) begin
        send_word(OP_RX_CHAR, bad_reply_byte());
        return;
      end else begin
        send_word(OP_RX_CHAR, CH_ACK);
        break;
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      send_word(OP_RX_CHAR, byte_except_c());
      return;
    end
    send_word(OP_RX_CHAR, CH_C);
    forever begin
      pull_frame(done);
      if (!done) return;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_word(OP_RX_CHAR, CH_ACK);
        return;
      end else if (pick < 90) begin
        send_word(OP_RX_CHAR, CH_NAK);
      end else begin
        send_word(OP_RX_CHAR, bad_reply_byte());
        return;
      end
    end
  endtask

  // A well-formed transfer with random content. Start is legal in any phase,
  // so it also recovers from whatever the noise left behind.
  task automatic run_session();
    int nblk;
    send_word(OP_START, rand_byte());
    if ($urandom_range(0, 9) == 0) begin
      send_word(OP_RX_CHAR, byte_except_c());
      return;
    end
    send_word(OP_RX_CHAR, CH_C);
    nblk = $urandom_range(0, 3);
    for (int b = 0; b < nblk; b++) begin
      // await C between blocks keeps the packet number running
      if ($urandom_range(0, 4) == 0) begin
        send_word(OP_AWAIT_C, rand_byte());
        send_word(OP_RX_CHAR, CH_C);
      end
      run_block();
    end
    run_end();
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: rejections in idle, while waiting for C and during EOT transmit, field extremes, the EOT flow.
    send_word(OP_PULL, 8'h00);          // nothing to send
    send_word(OP_RX_CHAR, 8'h00);       // stray character in idle
    send_word(OP_RX_CHAR, 8'hFF);
    send_word(OP_FLUSH, 8'hFF);         // empty flush is quiet
    send_word(OP_AWAIT_C, 8'h00);
    send_word(OP_ADD, 8'hFF);           // idle-only ops while waiting for C
    send_word(OP_FLUSH, 8'h00);
    send_word(OP_END, 8'hFF);
    send_word(OP_AWAIT_C, 8'hFF);
    send_word(OP_RX_CHAR, 8'h42);       // wrong character while waiting for C
    send_word(OP_START, 8'hFF);
    send_word(OP_PULL, 8'hFF);
    send_word(OP_RX_CHAR, CH_C);
    send_word(OP_END, 8'h00);
    send_word(OP_ADD, 8'h00);           // rejected during EOT transmit
    send_word(OP_RX_CHAR, CH_ACK);      // stray: EOT not sent yet
    send_word(OP_PULL, 8'h00);
    send_word(OP_RX_CHAR, CH_NAK);      // EOT again
    send_word(OP_PULL, 8'h00);
    send_word(OP_RX_CHAR, CH_ACK);
    send_word(OP_RX_CHAR, 8'hFF);       // not 'C' after the EOT was acked
    send_word(OP_END, 8'h00);
    send_word(OP_PULL, 8'h00);
    send_word(OP_RX_CHAR, 8'h00);       // bad reply to EOT
    wait_results_drained();

    // Random: mostly full sessions, some noise words, occasional full drains.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(ybs_op_e'($urandom_range(0, 6)), rand_byte());
        end
      end else begin
        run_session();
      end
      if ($urandom_range(0, 9) == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- ymodem_block_sender_unit.f -----
src/ybs_pkg.sv
src/ybs_ram.sv
src/ybs_proto.sv
src/ymodem_block_sender_unit.sv
verif/ybs_frame_checker.sv
verif/tb_ymodem_block_sender_unit.sv
